[sv/ctsc_pkg.sv]
// Package for the comfort turn-signal controller.
// Holds mode and phase codes, register indexes, timer width and shared types.
// No dependencies.
package ctsc_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CMP_W      = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        MD_OFF    = 3'd0,
        MD_LEFT   = 3'd1,
        MD_RIGHT  = 3'd2,
        MD_HAZARD = 3'd3,
        MD_PREOFF = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        PH_WAIT_FB = 2'd0,
        PH_SCAN    = 2'd1,
        PH_CONFIRM = 2'd2
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT      = 3'd0,
        REG_SCAN_DELAY   = 3'd1,
        REG_CONFIRM      = 3'd2,
        REG_QUIET        = 3'd3,
        REG_TURN_LIMIT   = 3'd4,
        REG_HAZARD_LIMIT = 3'd5,
        REG_RECHECK_GAP  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [9:0]  scan_delay_ms;
        logic [9:0]  confirm_delay_ms;
        logic [15:0] quiet_delay_ms;
        logic [7:0]  turn_edge_limit;
        logic [7:0]  hazard_edge_limit;
        logic [3:0]  recheck_gap_ms;
    } cfg_t;

    typedef struct packed {
        logic  left_lamp;
        logic  right_lamp;
        mode_t mode_now;
    } res_t;

    // Direction code of a stalk sample: left only, right only, both, none.
    function automatic logic [1:0] req_pattern(input logic l, input logic r);
        logic [1:0] p;
        p = 2'(MD_OFF);
        if (l && !r) begin
            p = 2'(MD_LEFT);
        end else if (r && !l) begin
            p = 2'(MD_RIGHT);
        end else if (l && r) begin
            p = 2'(MD_HAZARD);
        end
        return p;
    endfunction

endpackage

[sv/comfort_turn_signal_controller.sv]
// Top level of the comfort turn-signal controller: input register, core, result register.
// Depends on ctsc_pkg, ctsc_cfg and ctsc_core.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------
//  input   | s_left_req s_right_req s_flasher_fb     | s_valid / s_ready
//  result  | m_left_lamp m_right_lamp m_mode_now     | m_valid / m_ready
//  config  | cfg_index cfg_wdata                     | cfg_wr_en
//
// One item per cycle sustained while the result side is not stalled; an accepted item
// waits in the input register until it advances, and then its result is loaded into
// the result register, which raises m_valid.
// The core state steps when the input register hands its item to the result register.
// Reset is synchronous and active low; it clears the valid flags and the core state.
// A stalled result holds; the input register still takes one item behind it.
module comfort_turn_signal_controller (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_left_req,
    input  logic                            s_right_req,
    input  logic                            s_flasher_fb,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_left_lamp,
    output logic                            m_right_lamp,
    output logic [2:0]                      m_mode_now,
    input  logic                            cfg_wr_en,
    input  logic [ctsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ctsc_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t res_reg;

    logic in_vld_reg;
    logic in_l_reg, in_r_reg, in_fb_reg;
    logic out_vld_reg;
    logic advance;
    logic take;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign take    = s_valid && s_ready;

    ctsc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ctsc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .left_req   (in_l_reg),
        .right_req  (in_r_reg),
        .flasher_fb (in_fb_reg),
        .cfg        (cfg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (take) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_l_reg  <= s_left_req;
            in_r_reg  <= s_right_req;
            in_fb_reg <= s_flasher_fb;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_left_lamp  = res_reg.left_lamp;
    assign m_right_lamp = res_reg.right_lamp;
    assign m_mode_now   = res_reg.mode_now;

    // Input side stalls only while an item waits behind a held result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled without a held result");

    a_mode_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_mode_now <= 3'd4))
        else $error("mode code out of range");

    a_lamps_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_mode_now == MD_OFF || m_mode_now == MD_PREOFF))
        |-> (!m_left_lamp && !m_right_lamp))
        else $error("lamp on in off or pre-off");

    a_lamps_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_mode_now == MD_LEFT || m_mode_now == MD_RIGHT ||
                     m_mode_now == MD_HAZARD))
        |-> ({1'b0, m_right_lamp, m_left_lamp} == m_mode_now))
        else $error("lamp drive does not match active mode");

endmodule

[sv/ctsc_cfg.sv]
// Configuration register file for the turn-signal controller.
// Depends on ctsc_pkg for register indexes and the cfg_t struct.
module ctsc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ctsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output ctsc_pkg::cfg_t                  cfg
);
    import ctsc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ms        <= 16'd5000;
            cfg_reg.scan_delay_ms     <= 10'd50;
            cfg_reg.confirm_delay_ms  <= 10'd20;
            cfg_reg.quiet_delay_ms    <= 16'd250;
            cfg_reg.turn_edge_limit   <= 8'd5;
            cfg_reg.hazard_edge_limit <= 8'd3;
            cfg_reg.recheck_gap_ms    <= 4'd5;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TIMEOUT:      cfg_reg.timeout_ms        <= cfg_wdata[15:0];
                REG_SCAN_DELAY:   cfg_reg.scan_delay_ms     <= cfg_wdata[9:0];
                REG_CONFIRM:      cfg_reg.confirm_delay_ms  <= cfg_wdata[9:0];
                REG_QUIET:        cfg_reg.quiet_delay_ms    <= cfg_wdata[15:0];
                REG_TURN_LIMIT:   cfg_reg.turn_edge_limit   <= cfg_wdata[7:0];
                REG_HAZARD_LIMIT: cfg_reg.hazard_edge_limit <= cfg_wdata[7:0];
                REG_RECHECK_GAP:  cfg_reg.recheck_gap_ms    <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/ctsc_core.sv]
// Mode state and per-tick next-state logic of the turn-signal controller.
// Depends on ctsc_pkg; state advances only when step is high.
module ctsc_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  logic           left_req,
    input  logic           right_req,
    input  logic           flasher_fb,
    input  ctsc_pkg::cfg_t cfg,
    output ctsc_pkg::res_t res
);
    import ctsc_pkg::*;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    mode_t                 mode_reg, mode_next;
    phase_t                phase_reg, phase_next;
    logic [1:0]            cand_reg, cand_next;
    logic [TIMER_BITS-1:0] ms_reg, ms_next;
    logic [7:0]            edge_reg, edge_next;
    logic                  prev_fb_reg;
    logic [3:0]            gap_reg, gap_next;
    logic                  first_reg, first_next;
    logic [1:0]            lamp_reg, lamp_next;

    logic                  opp;
    logic                  change;
    logic [1:0]            pat;

    always_comb begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        cand_next  = cand_reg;
        gap_next   = gap_reg;
        first_next = first_reg;
        lamp_next  = lamp_reg;
        change     = 1'b0;
        opp        = (mode_reg == MD_LEFT) ? right_req : left_req;
        pat        = req_pattern(left_req, right_req);

        ms_next   = (ms_reg < TIMER_MAX) ? ms_reg + 1'b1 : ms_reg;
        edge_next = ((flasher_fb != prev_fb_reg) && (edge_reg != 8'hFF)) ?
                    edge_reg + 8'd1 : edge_reg;

        unique case (mode_reg)
            MD_LEFT, MD_RIGHT: begin
                if (!first_reg) begin
                    if (flasher_fb && opp) begin
                        first_next = 1'b1;
                        gap_next   = 4'd0;
                    end
                end else begin
                    gap_next = (gap_reg != 4'hF) ? gap_reg + 4'd1 : gap_reg;
                    if (gap_next >= cfg.recheck_gap_ms) begin
                        change     = flasher_fb && opp;
                        first_next = 1'b0;
                        gap_next   = 4'd0;
                    end
                end
                if (edge_next >= cfg.turn_edge_limit || change ||
                    CMP_W'(ms_next) > CMP_W'(cfg.timeout_ms)) begin
                    mode_next  = MD_PREOFF;
                    ms_next    = '0;
                    lamp_next  = 2'd0;
                    first_next = 1'b0;
                    gap_next   = 4'd0;
                end
            end
            MD_HAZARD: begin
                if (edge_next >= cfg.hazard_edge_limit ||
                    CMP_W'(ms_next) > CMP_W'(cfg.timeout_ms)) begin
                    mode_next  = MD_PREOFF;
                    ms_next    = '0;
                    lamp_next  = 2'd0;
                    first_next = 1'b0;
                    gap_next   = 4'd0;
                end
            end
            MD_PREOFF: begin
                lamp_next = 2'd0;
                if (left_req || right_req || flasher_fb) begin
                    ms_next = '0;
                end
                if (CMP_W'(ms_next) >= CMP_W'(cfg.quiet_delay_ms)) begin
                    mode_next  = MD_OFF;
                    phase_next = PH_WAIT_FB;
                    cand_next  = 2'd0;
                end
            end
            default: begin
                // Off, and any unused mode code, behave as off.
                mode_next = MD_OFF;
                unique case (phase_reg)
                    PH_SCAN: begin
                        if (CMP_W'(ms_next) >= CMP_W'(cfg.scan_delay_ms)) begin
                            cand_next  = pat;
                            phase_next = (pat != 2'd0) ? PH_CONFIRM : PH_WAIT_FB;
                            ms_next    = '0;
                        end
                    end
                    PH_CONFIRM: begin
                        if (CMP_W'(ms_next) >= CMP_W'(cfg.confirm_delay_ms)) begin
                            if (pat == cand_reg && cand_reg != 2'd0) begin
                                mode_next  = mode_t'({1'b0, cand_reg});
                                lamp_next  = cand_reg;
                                edge_next  = 8'd0;
                                first_next = 1'b0;
                                gap_next   = 4'd0;
                            end
                            ms_next    = '0;
                            phase_next = PH_WAIT_FB;
                            cand_next  = 2'd0;
                        end
                    end
                    default: begin
                        phase_next = PH_WAIT_FB;
                        if (flasher_fb) begin
                            phase_next = PH_SCAN;
                            ms_next    = '0;
                        end
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MD_OFF;
            phase_reg   <= PH_WAIT_FB;
            cand_reg    <= 2'd0;
            ms_reg      <= '0;
            edge_reg    <= 8'd0;
            prev_fb_reg <= 1'b0;
            gap_reg     <= 4'd0;
            first_reg   <= 1'b0;
            lamp_reg    <= 2'd0;
        end else if (step) begin
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            cand_reg    <= cand_next;
            ms_reg      <= ms_next;
            edge_reg    <= edge_next;
            prev_fb_reg <= flasher_fb;
            gap_reg     <= gap_next;
            first_reg   <= first_next;
            lamp_reg    <= lamp_next;
        end
    end

    assign res.left_lamp  = lamp_next[0];
    assign res.right_lamp = lamp_next[1];
    assign res.mode_now   = mode_next;

endmodule

[tb/testbench.sv]
// Testbench for comfort_turn_signal_controller: per-tick lamp/mode prediction, scoreboard
// checking and random flasher sequences under changing register settings.
// Depends on ctsc_pkg and the controller RTL only.
module testbench;
    import ctsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 800;
    localparam int PHASE_ITEMS  = 120;
    localparam int SETTLE       = 4;

    typedef enum int {
        SEQ_GOOD,
        SEQ_NO_REQ,
        SEQ_BAD_CONFIRM,
        SEQ_ANY
    } seq_kind_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_left_req;
    logic                  s_right_req;
    logic                  s_flasher_fb;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_left_lamp;
    logic                  m_right_lamp;
    logic [2:0]            m_mode_now;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Register copy and controller state as the predictor sees it
    cfg_t cfg_now = '{timeout_ms: 16'd5000, scan_delay_ms: 10'd50,
                      confirm_delay_ms: 10'd20, quiet_delay_ms: 16'd250,
                      turn_edge_limit: 8'd5, hazard_edge_limit: 8'd3,
                      recheck_gap_ms: 4'd5};
    mode_t                 pr_mode       = MD_OFF;
    phase_t                pr_phase      = PH_WAIT_FB;
    mode_t                 pr_cand       = MD_OFF;
    logic [TIMER_BITS-1:0] pr_ms         = '0;
    logic [7:0]            pr_edges      = '0;
    logic                  pr_prev_fb    = 1'b0;
    logic [3:0]            pr_gap        = '0;
    logic                  pr_first_seen = 1'b0;
    logic                  pr_left_lamp  = 1'b0;
    logic                  pr_right_lamp = 1'b0;

    res_t lamp_expect_q[$];
    int   items_sent      = 0;
    int   results_checked = 0;
    int   mismatches      = 0;
    int   settings_used   = 0;
    bit   idle_en         = 1'b1;
    int   hold_asks       = 0;
    int   holds_served    = 0;
    int   hold_left       = 0;
    int   stall_left      = 0;

    comfort_turn_signal_controller DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_left_req   (s_left_req),
        .s_right_req  (s_right_req),
        .s_flasher_fb (s_flasher_fb),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_left_lamp  (m_left_lamp),
        .m_right_lamp (m_right_lamp),
        .m_mode_now   (m_mode_now),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic bit is_active(input mode_t m);
        return m == MD_LEFT || m == MD_RIGHT || m == MD_HAZARD;
    endfunction

    function automatic mode_t stalk_code(input logic l, input logic r);
        if (l && !r) return MD_LEFT;
        if (r && !l) return MD_RIGHT;
        if (l && r)  return MD_HAZARD;
        return MD_OFF;
    endfunction

    function automatic cfg_t make_cfg(input int tmo, input int scan, input int conf,
                                      input int quiet, input int turn, input int haz,
                                      input int gap);
        cfg_t c;
        c.timeout_ms        = 16'(tmo);
        c.scan_delay_ms     = 10'(scan);
        c.confirm_delay_ms  = 10'(conf);
        c.quiet_delay_ms    = 16'(quiet);
        c.turn_edge_limit   = 8'(turn);
        c.hazard_edge_limit = 8'(haz);
        c.recheck_gap_ms    = 4'(gap);
        return c;
    endfunction

    function automatic cfg_t random_cfg();
        int tmo;
        tmo = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 30) : $urandom_range(31, 65535);
        return make_cfg(tmo, $urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 8),
                        $urandom_range(0, 10), $urandom_range(0, 10), $urandom_range(0, 15));
    endfunction

    function automatic void enter_preoff();
        pr_mode       = MD_PREOFF;
        pr_ms         = '0;
        pr_left_lamp  = 1'b0;
        pr_right_lamp = 1'b0;
        pr_first_seen = 1'b0;
        pr_gap        = '0;
    endfunction

    // Advance the controller state by one millisecond tick and return the lamp/mode item
    function automatic res_t predict_tick(input logic l, input logic r, input logic fb);
        logic  opp;
        logic  chg;
        mode_t code;
        res_t  y;
        chg  = 1'b0;
        code = stalk_code(l, r);
        if (pr_ms != {TIMER_BITS{1'b1}}) pr_ms = pr_ms + 1'b1;
        if (fb != pr_prev_fb && pr_edges != 8'hFF) pr_edges = pr_edges + 1'b1;
        pr_prev_fb = fb;

        if (pr_mode == MD_LEFT || pr_mode == MD_RIGHT) begin
            opp = (pr_mode == MD_LEFT) ? r : l;
            if (!pr_first_seen) begin
                if (fb && opp) begin
                    pr_first_seen = 1'b1;
                    pr_gap        = '0;
                end
            end else begin
                if (pr_gap != 4'hF) pr_gap = pr_gap + 1'b1;
                if (pr_gap >= cfg_now.recheck_gap_ms) begin
                    chg           = fb && opp;
                    pr_first_seen = 1'b0;
                    pr_gap        = '0;
                end
            end
            if (pr_edges >= cfg_now.turn_edge_limit || chg || pr_ms > cfg_now.timeout_ms) begin
                enter_preoff();
            end
        end else if (pr_mode == MD_HAZARD) begin
            if (pr_edges >= cfg_now.hazard_edge_limit || pr_ms > cfg_now.timeout_ms) begin
                enter_preoff();
            end
        end else if (pr_mode == MD_PREOFF) begin
            pr_left_lamp  = 1'b0;
            pr_right_lamp = 1'b0;
            if (l || r || fb) pr_ms = '0;
            if (pr_ms >= cfg_now.quiet_delay_ms) begin
                pr_mode  = MD_OFF;
                pr_phase = PH_WAIT_FB;
                pr_cand  = MD_OFF;
            end
        end else begin
            pr_mode = MD_OFF;
            case (pr_phase)
                PH_SCAN: begin
                    if (pr_ms >= cfg_now.scan_delay_ms) begin
                        pr_cand  = code;
                        pr_phase = (code != MD_OFF) ? PH_CONFIRM : PH_WAIT_FB;
                        pr_ms    = '0;
                    end
                end
                PH_CONFIRM: begin
                    if (pr_ms >= cfg_now.confirm_delay_ms) begin
                        if (code == pr_cand && pr_cand != MD_OFF) begin
                            pr_mode       = pr_cand;
                            pr_left_lamp  = (pr_cand == MD_LEFT || pr_cand == MD_HAZARD);
                            pr_right_lamp = (pr_cand == MD_RIGHT || pr_cand == MD_HAZARD);
                            pr_edges      = '0;
                            pr_first_seen = 1'b0;
                            pr_gap        = '0;
                        end
                        pr_ms    = '0;
                        pr_phase = PH_WAIT_FB;
                        pr_cand  = MD_OFF;
                    end
                end
                default: begin
                    pr_phase = PH_WAIT_FB;
                    if (fb) begin
                        pr_phase = PH_SCAN;
                        pr_ms    = '0;
                    end
                end
            endcase
        end

        y.left_lamp  = pr_left_lamp;
        y.right_lamp = pr_right_lamp;
        y.mode_now   = pr_mode;
        return y;
    endfunction

    // Offer one tick, hold it until accepted, then record what it should produce
    task automatic send_tick(input logic l, input logic r, input logic fb);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_left_req   <= l;
        s_right_req  <= r;
        s_flasher_fb <= fb;
        do @(posedge aclk); while (!s_ready);
        lamp_expect_q.push_back(predict_tick(l, r, fb));
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (lamp_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic load_config(input cfg_t c);
        wait_idle();
        put_reg(REG_TIMEOUT,      c.timeout_ms);
        put_reg(REG_SCAN_DELAY,   CFG_DATA_W'(c.scan_delay_ms));
        put_reg(REG_CONFIRM,      CFG_DATA_W'(c.confirm_delay_ms));
        put_reg(REG_QUIET,        c.quiet_delay_ms);
        put_reg(REG_TURN_LIMIT,   CFG_DATA_W'(c.turn_edge_limit));
        put_reg(REG_HAZARD_LIMIT, CFG_DATA_W'(c.hazard_edge_limit));
        put_reg(REG_RECHECK_GAP,  CFG_DATA_W'(c.recheck_gap_ms));
        cfg_wr_en <= 1'b0;
        cfg_now = c;
        settings_used++;
    endtask

    // One flasher episode: settle to off, request, confirm, flash, then quiet down
    task automatic run_sequence(input seq_kind_t kind_in);
        seq_kind_t kind;
        mode_t     want;
        int        period;
        int        ticks;
        int        swap_at;
        int        busy;
        bit        swap;
        logic      l;
        logic      r;
        logic      fb;
        kind = kind_in;
        while (!(pr_mode == MD_OFF && pr_phase == PH_WAIT_FB)) begin
            if (is_active(pr_mode)) send_tick(1'b0, 1'b0, ~pr_prev_fb);
            else send_tick(1'b0, 1'b0, 1'b0);
        end
        if (kind == SEQ_ANY) begin
            case ($urandom_range(0, 9))
                0:       kind = SEQ_NO_REQ;
                1:       kind = SEQ_BAD_CONFIRM;
                default: kind = SEQ_GOOD;
            endcase
        end
        want = mode_t'($urandom_range(1, 3));
        repeat ($urandom_range(0, 2)) send_tick(coin(), coin(), 1'b0);
        send_tick(coin(), coin(), 1'b1);

        while (pr_phase == PH_SCAN && int'(pr_ms) + 1 < int'(cfg_now.scan_delay_ms)) begin
            send_tick(coin(), coin(), coin());
        end
        if (pr_phase == PH_SCAN) begin
            if (kind == SEQ_NO_REQ) send_tick(1'b0, 1'b0, coin());
            else send_tick(want[0], want[1], coin());
        end

        while (pr_phase == PH_CONFIRM && int'(pr_ms) + 1 < int'(cfg_now.confirm_delay_ms)) begin
            send_tick(coin(), coin(), coin());
        end
        if (pr_phase == PH_CONFIRM) begin
            if (kind == SEQ_BAD_CONFIRM) begin
                do {r, l} = 2'($urandom_range(0, 3)); while ({r, l} == want[1:0]);
                send_tick(l, r, coin());
            end else begin
                send_tick(want[0], want[1], coin());
            end
        end

        // Flash; a turn may get the opposite stalk held to force a direction change
        period  = $urandom_range(1, 4);
        ticks   = 0;
        fb      = pr_prev_fb;
        swap    = (want != MD_HAZARD) && ($urandom_range(0, 2) == 0);
        swap_at = $urandom_range(0, 12);
        while (is_active(pr_mode)) begin
            if (ticks % period == period - 1 || ticks > 40) fb = ~fb;
            if (swap && ticks >= swap_at) begin
                l = want[1];
                r = want[0];
            end else begin
                l = want[0] ^ ($urandom_range(0, 9) == 0);
                r = want[1] ^ ($urandom_range(0, 9) == 0);
            end
            send_tick(l, r, fb);
            ticks++;
        end

        busy = $urandom_range(0, 3);
        while (pr_mode == MD_PREOFF) begin
            if (busy > 0) begin
                send_tick(coin(), coin(), coin());
                busy--;
            end else begin
                send_tick(1'b0, 1'b0, 1'b0);
            end
        end
    endtask

    task automatic test_reset_values();
        run_sequence(SEQ_GOOD);
    endtask

    task automatic test_rejected_requests();
        load_config(make_cfg(65535, 0, 0, 0, 2, 0, 1));
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b1);    // scan sees no stalk
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);    // confirm disagrees
    endtask

    task automatic test_direction_change();
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);    // second opposite sample: leave left
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b0);    // feedback dropped: forget first sample
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_exit_conditions();
        // zero hazard edge limit ends on the first active tick
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        load_config(make_cfg(0, 0, 0, 0, 255, 255, 1));
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1);    // timer passes a zero timeout
        send_tick(1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_extreme_settings();
        load_config(make_cfg(0, 0, 0, 0, 0, 0, 0));
        repeat (4) run_sequence(SEQ_ANY);
        load_config(make_cfg(65535, 1023, 1023, 65535, 255, 255, 15));
        send_tick(1'b0, 1'b0, 1'b1);
        repeat (20) send_tick(coin(), coin(), coin());
        load_config(make_cfg(65535, 0, 0, 0, 255, 255, 15));
        run_sequence(SEQ_GOOD);
    endtask

    task automatic test_backpressure();
        load_config(make_cfg(40, 2, 1, 3, 6, 4, 3));
        idle_en = 1'b0;
        hold_asks <= hold_asks + 1;
        run_sequence(SEQ_GOOD);
        idle_en = 1'b1;
    endtask

    task automatic test_random_settings();
        int random_items;
        int phase_start;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            load_config(random_cfg());
            // keep the last stretch free of idling on both sides
            if (random_items + PHASE_ITEMS >= RANDOM_ITEMS) idle_en = 1'b0;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) run_sequence(SEQ_ANY);
            random_items += items_sent - phase_start;
        end
    endtask

    // Result side: random stall bursts, plus long holds on request
    always @(posedge aclk) begin
        if (hold_asks != holds_served) begin
            holds_served <= hold_asks;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        res_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (lamp_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: left=%0b right=%0b mode=%0d",
                             m_left_lamp, m_right_lamp, m_mode_now);
                end
            end else begin
                exp_item = lamp_expect_q.pop_front();
                results_checked++;
                if (m_left_lamp !== exp_item.left_lamp ||
                    m_right_lamp !== exp_item.right_lamp ||
                    m_mode_now !== exp_item.mode_now) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"mismatch at item %0d: expected left=%0b right=%0b ",
                                  "mode=%0d, got left=%0b right=%0b mode=%0d"},
                                 results_checked, exp_item.left_lamp, exp_item.right_lamp,
                                 exp_item.mode_now, m_left_lamp, m_right_lamp, m_mode_now);
                    end
                end
            end
        end
    end

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_left_req   <= 1'b0;
        s_right_req  <= 1'b0;
        s_flasher_fb <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_TIMEOUT;
        cfg_wdata    <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_rejected_requests();
        test_direction_change();
        test_exit_conditions();
        test_extreme_settings();
        test_backpressure();
        test_random_settings();

        wait_idle();
        $display("Checked %0d lamp/mode items from %0d ticks under %0d register settings.",
                 results_checked, items_sent, settings_used);
        $display("Mix: turns, hazard, rejected requests, direction changes, limits, back-pressure.");
        if (mismatches == 0 && lamp_expect_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d items outstanding", mismatches, lamp_expect_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d items outstanding", lamp_expect_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
